[hdl/hfx_pkg.sv]
// ----------------------------------------------------------------------------
// hfx_pkg
// Shared types and constants for the half-duplex frame exchange block.
// ----------------------------------------------------------------------------
package hfx_pkg;

  // byte and output index widths fixed by the channel format
  localparam int unsigned DataW = 8;
  localparam int unsigned IdxW  = 5;

  // request phase: two echoes expected after the first byte
  localparam logic [1:0] TxStart = 2'd2;

  // link reload value after reset
  localparam logic [DataW-1:0] ReloadRst = 8'd10;

  // first stored position that goes out on a match
  localparam int unsigned FirstOut = 2;

  // result kinds
  localparam logic KindTx    = 1'b0;
  localparam logic KindFrame = 1'b1;

  // frame memory strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[hdl/hfx_if.sv]
// ----------------------------------------------------------------------------
// hfx_in_if / hfx_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface hfx_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic       rx_error;
  logic [7:0] tx_first;
  logic [7:0] tx_second;

  modport source (output valid, output mode, output rx_byte, output rx_error,
                  output tx_first, output tx_second, input ready);
  modport sink   (input valid, input mode, input rx_byte, input rx_error,
                  input tx_first, input tx_second, output ready);
endinterface

interface hfx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic       ninth_bit;
  logic [4:0] frame_index;
  logic       driver_on;
  logic       last;

  modport source (output valid, output kind, output data, output ninth_bit,
                  output frame_index, output driver_on, output last, input ready);
  modport sink   (input valid, input kind, input data, input ninth_bit,
                  input frame_index, input driver_on, input last, output ready);
endinterface

[hdl/hfx_frame_mem.sv]
// ----------------------------------------------------------------------------
// hfx_frame_mem
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hfx_frame_mem
  import hfx_pkg::*;
#(
  parameter int unsigned Depth = 17,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/hfx_core.sv]
// ----------------------------------------------------------------------------
// hfx_core
// Link sequencer: request timer, transmit and receive phases, one shared
// 8-bit checksum adder, and the emit loop that walks the frame store.
// ----------------------------------------------------------------------------
module hfx_core
  import hfx_pkg::*;
#(
  parameter int unsigned FrameLen = 16,
  parameter int unsigned AddrW    = $clog2(FrameLen + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  hfx_in_if.sink           in_i,
  hfx_out_if.source        out_o,
  output mem_ctl_t         mem_ctl_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [DataW-1:0] mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [DataW-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StSend
  } state_e;

  localparam logic [AddrW-1:0] LenA   = AddrW'(FrameLen);
  localparam logic [AddrW-1:0] FirstA = AddrW'(FirstOut);
  localparam logic [AddrW-1:0] OneA   = AddrW'(1);

  state_e           state_q, state_d;
  logic [DataW-1:0] reload_q, reload_d;
  logic [DataW-1:0] link_cnt_q, link_cnt_d;
  logic [1:0]       tx_left_q, tx_left_d;
  logic [DataW-1:0] tx_sum_q, tx_sum_d;
  logic [AddrW-1:0] rx_left_q, rx_left_d;
  logic [DataW-1:0] rx_sum_q, rx_sum_d;
  logic             driver_q, driver_d;
  logic [AddrW-1:0] idx_q, idx_d;

  logic             ovalid_q, ovalid_d;
  logic             okind_q, okind_d;
  logic [DataW-1:0] odata_q, odata_d;
  logic             oninth_q, oninth_d;
  logic [IdxW-1:0]  oidx_q, oidx_d;
  logic             odrv_q, odrv_d;
  logic             olast_q, olast_d;

  logic             slot_free;
  logic             accept;
  logic             tx_phase;
  logic [DataW-1:0] add_a, add_b, add_sum;

  // output slot can be loaded when empty or draining this cycle
  assign slot_free  = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && slot_free;
  assign accept     = in_i.valid && in_i.ready;

  // shared checksum adder
  assign tx_phase = (tx_left_q != 2'd0);
  assign add_a    = tx_phase ? tx_sum_q : rx_sum_q;
  assign add_b    = tx_phase ? in_i.tx_second : in_i.rx_byte;
  assign add_sum  = add_a + add_b;

  // memory addressing
  assign mem_waddr_o = rx_left_q;
  assign mem_wdata_o = in_i.rx_byte;
  assign mem_raddr_o = idx_q;

  // next state
  always_comb begin
    state_d    = state_q;
    reload_d   = reload_q;
    link_cnt_d = link_cnt_q;
    tx_left_d  = tx_left_q;
    tx_sum_d   = tx_sum_q;
    rx_left_d  = rx_left_q;
    rx_sum_d   = rx_sum_q;
    driver_d   = driver_q;
    idx_d      = idx_q;
    ovalid_d   = ovalid_q && !out_o.ready;
    okind_d    = okind_q;
    odata_d    = odata_q;
    oninth_d   = oninth_q;
    oidx_d     = oidx_q;
    odrv_d     = odrv_q;
    olast_d    = olast_q;
    mem_ctl_o  = '0;

    if (cfg_we_i) begin
      reload_d = cfg_wdata_i;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!in_i.mode && (link_cnt_q != '0)) begin
            // tick while counting down
            link_cnt_d = link_cnt_q - 1'b1;
          end else if (!in_i.mode || in_i.rx_error) begin
            // timeout or receive error: start a request
            driver_d   = 1'b1;
            link_cnt_d = reload_q;
            tx_sum_d   = in_i.tx_first;
            tx_left_d  = TxStart;
            ovalid_d   = 1'b1;
            okind_d    = KindTx;
            odata_d    = in_i.tx_first;
            oninth_d   = 1'b1;
            oidx_d     = '0;
            odrv_d     = 1'b1;
            olast_d    = 1'b1;
          end else if (tx_phase) begin
            // echo: send second byte, then the checksum
            tx_left_d = tx_left_q - 1'b1;
            ovalid_d  = 1'b1;
            okind_d   = KindTx;
            oninth_d  = 1'b0;
            oidx_d    = '0;
            odrv_d    = driver_q;
            olast_d   = 1'b1;
            if (tx_left_q == 2'd1) begin
              odata_d   = tx_sum_q;
              rx_left_d = LenA;
            end else begin
              odata_d  = in_i.tx_second;
              tx_sum_d = add_sum;
            end
          end else begin
            // reception: store every word, driver off
            driver_d        = 1'b0;
            mem_ctl_o.wr_en = 1'b1;
            if (rx_left_q != '0) begin
              if (rx_left_q == LenA) begin
                rx_sum_d = '0;
              end else if (rx_left_q == OneA) begin
                if (in_i.rx_byte == rx_sum_q) begin
                  state_d = StRead;
                  idx_d   = FirstA;
                end
              end else begin
                rx_sum_d = add_sum;
              end
              rx_left_d = rx_left_q - 1'b1;
            end
          end
        end
      end
      StRead: begin
        // fetch the next stored byte
        mem_ctl_o.rd_en = 1'b1;
        state_d         = StSend;
      end
      StSend: begin
        // emit stored byte once the output slot is free
        if (slot_free) begin
          ovalid_d = 1'b1;
          okind_d  = KindFrame;
          odata_d  = mem_rdata_i;
          oninth_d = 1'b0;
          oidx_d   = IdxW'(idx_q);
          odrv_d   = driver_q;
          olast_d  = (idx_q == LenA);
          if (idx_q == LenA) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      reload_q   <= ReloadRst;
      link_cnt_q <= '0;
      tx_left_q  <= '0;
      tx_sum_q   <= '0;
      rx_left_q  <= '0;
      rx_sum_q   <= '0;
      driver_q   <= 1'b1;
      idx_q      <= '0;
      ovalid_q   <= 1'b0;
      okind_q    <= 1'b0;
      odata_q    <= '0;
      oninth_q   <= 1'b0;
      oidx_q     <= '0;
      odrv_q     <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      reload_q   <= reload_d;
      link_cnt_q <= link_cnt_d;
      tx_left_q  <= tx_left_d;
      tx_sum_q   <= tx_sum_d;
      rx_left_q  <= rx_left_d;
      rx_sum_q   <= rx_sum_d;
      driver_q   <= driver_d;
      idx_q      <= idx_d;
      ovalid_q   <= ovalid_d;
      okind_q    <= okind_d;
      odata_q    <= odata_d;
      oninth_q   <= oninth_d;
      oidx_q     <= oidx_d;
      odrv_q     <= odrv_d;
      olast_q    <= olast_d;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.kind        = okind_q;
  assign out_o.data        = odata_q;
  assign out_o.ninth_bit   = oninth_q;
  assign out_o.frame_index = oidx_q;
  assign out_o.driver_on   = odrv_q;
  assign out_o.last        = olast_q;

endmodule

[hdl/half_duplex_frame_exchange.sv]
// ----------------------------------------------------------------------------
// half_duplex_frame_exchange
// Master side of a half-duplex byte link: timed requests with checksum,
// reply capture into a frame store, and emission of checked frames.
// ----------------------------------------------------------------------------
// input: an input word is taken when valid and ready are both high; its result
//   word is registered and on the output in the following cycle
// flow: one input word per cycle while idle with the output slot free; a
//   checked frame emits FRAME_LEN-1 words, each a frame store read, then an
//   output load, and no input word is taken during that run
// reset: asynchronous, active low; control state cleared, link reload 10,
//   driver on; the frame store is not cleared
module half_duplex_frame_exchange
  import hfx_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  hfx_in_if.sink           in_i,
  hfx_out_if.source        out_o
);

  localparam int unsigned Depth = FRAME_LEN + 1;
  localparam int unsigned AddrW = $clog2(Depth);

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;

  // sequencer with shared adder
  hfx_core #(
    .FrameLen (FRAME_LEN),
    .AddrW    (AddrW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // frame byte store
  hfx_frame_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[tb/sv/hfx_link_checker.sv]
// ----------------------------------------------------------------------------
// hfx_link_checker
// Watches the input and result channels of the frame exchange block, keeps a
// cycle-free copy of the link state, predicts the result words of each
// accepted input word and compares them field by field in arrival order.
// ----------------------------------------------------------------------------
module hfx_link_checker
  import hfx_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  hfx_in_if                in_i,
  hfx_out_if               out_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            kind;
    logic [DataW-1:0] data;
    logic            ninth_bit;
    logic [IdxW-1:0] frame_index;
    logic            driver_on;
    logic            last;
  } link_word_t;

  // words still owed by the block, oldest first
  link_word_t expected_words[$];
  link_word_t exp_w;

  // shadow link state
  logic [DataW-1:0] reload_q;
  logic [DataW-1:0] link_count;
  logic [1:0]       tx_left;
  logic [DataW-1:0] tx_sum;
  logic [IdxW-1:0]  rx_left;
  logic [DataW-1:0] rx_sum;
  logic [DataW-1:0] frame_store [0:FRAME_LEN];
  logic             driver_state;

  function automatic void push_word(logic k, logic [DataW-1:0] d, logic nb,
                                    logic [IdxW-1:0] idx, logic lst);
    expected_words.push_back('{k, d, nb, idx, driver_state, lst});
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors_o++;
    end
  endfunction

  // driver on, first byte out with address bit, two echoes to come
  function automatic void start_request(logic [DataW-1:0] first);
    driver_state = 1'b1;
    link_count   = reload_q;
    tx_sum       = first;
    tx_left      = TxStart;
    push_word(KindTx, first, 1'b1, '0, 1'b1);
  endfunction

  // one input word through the shadow state
  task automatic link_step(logic mode, logic [DataW-1:0] rx_byte, logic rx_err,
                           logic [DataW-1:0] first, logic [DataW-1:0] second);
    // timer tick
    if (!mode) begin
      if (link_count != 0) begin
        link_count = link_count - 1'b1;
      end else begin
        start_request(first);
      end
      return;
    end
    // receive error restarts the request
    if (rx_err) begin
      start_request(first);
      return;
    end
    // echo of a transmitted byte
    if (tx_left != 0) begin
      tx_left = tx_left - 1'b1;
      if (tx_left == 0) begin
        push_word(KindTx, tx_sum, 1'b0, '0, 1'b1);
        rx_left = IdxW'(FRAME_LEN);
      end else begin
        push_word(KindTx, second, 1'b0, '0, 1'b1);
        tx_sum = tx_sum + second;
      end
      return;
    end
    // reply byte: driver off, byte stored
    driver_state = 1'b0;
    if (rx_left <= FRAME_LEN) frame_store[rx_left] = rx_byte;
    if (rx_left == 0) return;
    if (rx_left == IdxW'(FRAME_LEN)) begin
      rx_sum = '0;
    end else if (rx_left == 1) begin
      if (rx_byte == rx_sum) begin
        for (int i = FirstOut; i <= FRAME_LEN; i++) begin
          push_word(KindFrame, frame_store[i], 1'b0, IdxW'(i), i == FRAME_LEN);
        end
      end
    end else begin
      rx_sum = rx_sum + rx_byte;
    end
    rx_left = rx_left - 1'b1;
  endtask

  // predict on accepted input words, compare accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q     = ReloadRst;
      link_count   = '0;
      tx_left      = '0;
      tx_sum       = '0;
      rx_left      = '0;
      rx_sum       = '0;
      driver_state = 1'b1;
      for (int i = 0; i <= FRAME_LEN; i++) frame_store[i] = '0;
      expected_words.delete();
      errors_o     = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) reload_q = cfg_wdata_i;
      if (in_i.valid && in_i.ready) begin
        link_step(in_i.mode, in_i.rx_byte, in_i.rx_error, in_i.tx_first, in_i.tx_second);
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation: data %0d", out_i.data);
          errors_o++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("kind", exp_w.kind, out_i.kind);
          check_field("data", exp_w.data, out_i.data);
          check_field("ninth_bit", exp_w.ninth_bit, out_i.ninth_bit);
          check_field("frame_index", exp_w.frame_index, out_i.frame_index);
          check_field("driver_on", exp_w.driver_on, out_i.driver_on);
          check_field("last", exp_w.last, out_i.last);
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the half-duplex frame exchange block: directed requests and
// replies first, then phases of random request/reply frames and noise at
// several link reload settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import hfx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameLen   = 16;
  localparam int          ClkHalf    = 4;
  localparam int          CycleLimit = 500000;
  localparam int          PhaseWords = 25;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [DataW-1:0] cfg_wdata;
  int               errors;
  int               pending;

  // stimulus side bookkeeping
  logic             quiet;
  logic [DataW-1:0] link_mirror;
  logic [DataW-1:0] reload_mirror;
  int               n_sent;
  int               stall_left;
  int               cycle_count;

  hfx_in_if  in_if ();
  hfx_out_if out_if ();

  half_duplex_frame_exchange #(
    .FRAME_LEN (FrameLen)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  hfx_link_checker #(
    .FRAME_LEN (FrameLen)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_i       (out_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #ClkHalf clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // drive one input word and wait until it is taken
  task automatic send_word(logic mode, logic [7:0] rx_byte, logic rx_err,
                           logic [7:0] first, logic [7:0] second);
    int gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.rx_byte   <= rx_byte;
    in_if.rx_error  <= rx_err;
    in_if.tx_first  <= first;
    in_if.tx_second <= second;
    do @(posedge clk_i); while (!in_if.ready);
    // track the link counter so frames never fire a stray request
    if (!mode) begin
      link_mirror = (link_mirror != 0) ? link_mirror - 1'b1 : reload_mirror;
    end else if (rx_err) begin
      link_mirror = reload_mirror;
    end
    n_sent++;
  endtask

  // write the reload register once the block has gone quiet
  task automatic write_reload(logic [7:0] value);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    reload_mirror = value;
  endtask

  // request, two echoes, discarded byte, payload, checksum
  // style: 0 good checksum, 1 bad checksum, 2 cut short
  task automatic run_frame(int style);
    logic [7:0] sum;
    logic [7:0] b;
    int         cut;
    int         r;
    sum = '0;
    cut = (style == 2) ? $urandom_range(1, FrameLen + 1) : FrameLen + 3;
    if (link_mirror == 0 && $urandom_range(0, 1) == 1) begin
      send_word(1'b0, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      send_word(1'b1, 8'($urandom), 1'b1, 8'($urandom), 8'($urandom));
    end
    for (int k = 0; k < FrameLen + 2; k++) begin
      if (k == cut) return;
      // harmless ticks while the counter is still running
      if (link_mirror != 0 && $urandom_range(0, 5) == 0) begin
        send_word(1'b0, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end
      r = $urandom_range(0, 7);
      b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      if (k >= 3 && k < FrameLen + 1) sum = sum + b;
      if (k == FrameLen + 1) begin
        b = (style == 1) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      end
      send_word(1'b1, b, 1'b0, 8'($urandom), 8'($urandom));
    end
  endtask

  // run timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] phase_reload [4];
    int         target;
    int         pick;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.mode      = 1'b0;
    in_if.rx_byte   = '0;
    in_if.rx_error  = 1'b0;
    in_if.tx_first  = '0;
    in_if.tx_second = '0;
    quiet           = 1'b0;
    link_mirror     = '0;
    reload_mirror   = ReloadRst;
    n_sent          = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tick at zero count starts a request
    send_word(1'b0, 8'h00, 1'b0, 8'hFF, 8'h00);
    // error flag on a tick is ignored, count runs down
    send_word(1'b0, 8'hFF, 1'b1, 8'h00, 8'hFF);
    // receive error starts a request and drops the byte
    send_word(1'b1, 8'hA5, 1'b1, 8'h00, 8'h00);
    // echoes: second byte, then checksum
    send_word(1'b1, 8'h00, 1'b0, 8'h00, 8'hFF);
    send_word(1'b1, 8'hFF, 1'b0, 8'hFF, 8'h12);
    // discarded byte and one payload byte
    send_word(1'b1, 8'hFF, 1'b0, 8'h00, 8'h00);
    send_word(1'b1, 8'h3C, 1'b0, 8'h00, 8'h00);
    // request in the middle of a reply re-arms the receiver
    send_word(1'b1, 8'h00, 1'b1, 8'h80, 8'h01);
    send_word(1'b1, 8'h55, 1'b0, 8'h00, 8'h01);
    send_word(1'b1, 8'hAA, 1'b0, 8'h00, 8'h01);
    // full reply with extreme bytes and a good checksum
    send_word(1'b1, 8'h00, 1'b0, 8'h00, 8'h00);
    sum = '0;
    for (int i = 0; i < FrameLen - 2; i++) begin
      b = (i % 2 == 0) ? 8'hFF : 8'h00;
      sum = sum + b;
      send_word(1'b1, b, 1'b0, 8'h00, 8'h00);
    end
    send_word(1'b1, sum, 1'b0, 8'h00, 8'h00);
    // byte on an idle receiver
    send_word(1'b1, 8'h77, 1'b0, 8'hFF, 8'hFF);

    // random phases at several reload settings
    phase_reload[0] = 8'h00;
    phase_reload[1] = 8'hFF;
    phase_reload[2] = 8'($urandom_range(1, 6));
    phase_reload[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      write_reload(phase_reload[p]);
      target = n_sent + PhaseWords;
      while (n_sent < target) begin
        quiet = ($urandom_range(0, 4) == 0);
        pick  = $urandom_range(0, 9);
        if (pick < 6) begin
          run_frame(0);
        end else if (pick < 7) begin
          run_frame(1);
        end else if (pick < 8) begin
          run_frame(2);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_word(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0,
                      8'($urandom), 8'($urandom));
          end
        end
      end
    end

    // drain and settle
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/hfx_pkg.sv
hdl/hfx_if.sv
hdl/hfx_frame_mem.sv
hdl/hfx_core.sv
hdl/half_duplex_frame_exchange.sv
tb/sv/hfx_link_checker.sv
tb/sv/testbench.sv
